/* rtl/core/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// shared constants, types and helpers for the text console character engine
// ----------------------------------------------------------------------------
package tcce_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 8;   // power of two, tab stop found by masking
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // field widths
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int NIB_W  = 4;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int IDX_W  = 11;
   localparam int CELL_W = 16;

   // sweep bounds
   localparam int LAST_COPY   = CELL_COUNT - COLUMNS - 1;
   localparam int BLANK_START = CELL_COUNT - COLUMNS;
   localparam int LAST_CELL   = CELL_COUNT - 1;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   // one write into the cell memory
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [CELL_W-1:0] data;
   } mem_wr_type;

   // cursor after a put
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             scroll;
   } cursor_next_type;

   // linear cell position of a cursor
   function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return IDX_W'(row * COLUMNS) + IDX_W'(col);
   endfunction

endpackage

/* rtl/core/tcce_if.sv */
// ----------------------------------------------------------------------------
// tcce request and response channels
// valid/ready channels carrying the engine's request and response payloads
// ----------------------------------------------------------------------------
interface tcce_req_if;
   import tcce_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [CHAR_W-1:0] char_code;
   logic [NIB_W-1:0]  background;
   logic [NIB_W-1:0]  foreground;
   logic [IDX_W-1:0]  read_index;

   modport source (output valid, command, char_code, background, foreground,
                   read_index, input ready);
   modport sink   (input valid, command, char_code, background, foreground,
                   read_index, output ready);
endinterface

interface tcce_rsp_if;
   import tcce_pkg::*;

   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic [IDX_W-1:0]  cursor_location;
   logic [CELL_W-1:0] read_data;

   modport source (output valid, cursor_col, cursor_row, cursor_location,
                   read_data, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_location,
                   read_data, output ready);
endinterface

/* rtl/core/tcce_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcce_screen_ram
// cell memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcce_screen_ram (
   input  logic                        clock,
   input  tcce_pkg::mem_wr_type        wr,
   input  logic [tcce_pkg::IDX_W-1:0]  rd_addr,
   output logic [tcce_pkg::CELL_W-1:0] rd_data
);
   import tcce_pkg::*;

   logic [CELL_W-1:0] cells [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cells[wr.addr] <= wr.data;
      end
      rd_data_ff <= cells[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tcce_cursor_step.sv */
// ----------------------------------------------------------------------------
// tcce_cursor_step
// decodes one put byte: cell write, cursor move, wrap and scroll request
// ----------------------------------------------------------------------------
module tcce_cursor_step (
   input  logic [tcce_pkg::COL_W-1:0]  col,
   input  logic [tcce_pkg::ROW_W-1:0]  row,
   input  logic [tcce_pkg::CHAR_W-1:0] char_code,
   input  logic [tcce_pkg::NIB_W-1:0]  background,
   input  logic [tcce_pkg::NIB_W-1:0]  foreground,
   output tcce_pkg::cursor_next_type   nxt,
   output tcce_pkg::mem_wr_type        wr
);
   import tcce_pkg::*;

   localparam logic [COL_W:0] TAB_MASK = (COL_W+1)'(TAB_WIDTH - 1);

   // one spare bit each for the overflow checks
   logic [COL_W:0] col_w;
   logic [ROW_W:0] row_w;

   always_comb begin
      col_w   = {1'b0, col};
      row_w   = {1'b0, row};
      wr.en   = 1'b0;
      wr.addr = cell_index(row, col);
      wr.data = {background, foreground, char_code};

      case (char_code)
         CHAR_BS: begin
            if (col != '0) begin
               col_w = col_w - 1'b1;
            end
         end
         CHAR_TAB: begin
            col_w = (col_w & ~TAB_MASK) + (COL_W+1)'(TAB_WIDTH);
         end
         CHAR_CR: begin
            col_w = '0;
         end
         CHAR_LF: begin
            col_w = '0;
            row_w = row_w + 1'b1;
         end
         default: begin
            if (char_code >= PRINT_LO && char_code <= PRINT_HI) begin
               wr.en = 1'b1;
               col_w = col_w + 1'b1;
            end
         end
      endcase

      // wrap past the last column
      if (col_w >= (COL_W+1)'(COLUMNS)) begin
         col_w = '0;
         row_w = row_w + 1'b1;
      end

      // past the last row: screen moves up one row
      nxt.scroll = (row_w >= (ROW_W+1)'(ROWS));
      if (nxt.scroll) begin
         row_w = (ROW_W+1)'(ROWS - 1);
      end

      nxt.col = col_w[COL_W-1:0];
      nxt.row = row_w[ROW_W-1:0];
   end

endmodule

/* rtl/core/text_console_char_engine.sv */
// ----------------------------------------------------------------------------
// text_console_char_engine
// text-mode character engine over an 80x25 memory of 16-bit cells
// ----------------------------------------------------------------------------
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------------
//   req     | in  | command, char_code, background, foreground, read_index
//   rsp     | out | cursor_col, cursor_row, cursor_location, read_data
//
// a put without scroll and a no-op load the response register on accept; a read
// loads it from ST_READ (registered memory read port)
// clear and a put that scrolls run one address sweep: the sweep
// counter walks the whole memory, one cell per cycle through its single
// write port
// reset clears the cursor and sequencer; cell contents stay undefined until
// written
// req.ready is low while a sweep or read runs, and when a response waits
// in the output register and rsp.ready is low
//
module text_console_char_engine (
   input  logic   clock,
   input  logic   reset,
   tcce_req_if.sink   req,
   tcce_rsp_if.source rsp
);
   import tcce_pkg::*;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_SCROLL = 4'b0100,
      ST_BLANK  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;          // sweep address counter
   logic              copy_pend_ff, copy_pend_in;
   logic [IDX_W-1:0]  copy_addr_ff, copy_addr_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic              read_oob_ff, read_oob_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [IDX_W-1:0]  rsp_loc_ff;
   logic [CELL_W-1:0] rsp_data_ff;

   logic              accept;
   logic              rsp_load;
   logic [COL_W-1:0]  load_col;
   logic [ROW_W-1:0]  load_row;
   logic [CELL_W-1:0] load_data;

   mem_wr_type        wr;
   mem_wr_type        step_wr;
   cursor_next_type   step_nxt;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  src_addr;
   logic [CELL_W-1:0] rd_data;

   // take a request only when idle and the response slot is free or draining
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   // scroll source: one row below the sweep address
   assign src_addr = IDX_W'(cnt_ff + IDX_W'(COLUMNS));
   assign rd_addr  = (state_ff == ST_IDLE) ? req.read_index : src_addr;

   tcce_cursor_step u_step (
      .col        (cursor_col_ff),
      .row        (cursor_row_ff),
      .char_code  (req.char_code),
      .background (req.background),
      .foreground (req.foreground),
      .nxt        (step_nxt),
      .wr         (step_wr)
   );

   tcce_screen_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      copy_pend_in  = 1'b0;
      copy_addr_in  = copy_addr_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      read_oob_in   = read_oob_ff;
      rsp_load      = 1'b0;
      load_col      = cursor_col_ff;
      load_row      = cursor_row_ff;
      load_data     = '0;
      wr            = '0;

      // copy of a scrolled cell lands in the cycle after its read
      if (copy_pend_ff) begin
         wr.en   = 1'b1;
         wr.addr = copy_addr_ff;
         wr.data = rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (command_type'(req.command))
                  CMD_PUT: begin
                     wr            = step_wr;
                     cursor_col_in = step_nxt.col;
                     cursor_row_in = step_nxt.row;
                     if (step_nxt.scroll) begin
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        rsp_load = 1'b1;
                        load_col = step_nxt.col;
                        load_row = step_nxt.row;
                     end
                  end
                  CMD_CLEAR: begin
                     cursor_col_in = '0;
                     cursor_row_in = '0;
                     cnt_in        = '0;
                     state_in      = ST_BLANK;
                  end
                  CMD_READ: begin
                     read_oob_in = (req.read_index >= IDX_W'(CELL_COUNT));
                     state_in    = ST_READ;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load  = 1'b1;
            load_data = read_oob_ff ? '0 : rd_data;
            state_in  = ST_IDLE;
         end
         ST_SCROLL: begin
            copy_pend_in = 1'b1;
            copy_addr_in = cnt_ff;
            if (cnt_ff == IDX_W'(LAST_COPY)) begin
               cnt_in   = IDX_W'(BLANK_START);
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            // last copy finishes first, then blanking starts
            if (!copy_pend_ff) begin
               wr.en   = 1'b1;
               wr.addr = cnt_ff;
               wr.data = BLANK_CELL;
               if (cnt_ff == IDX_W'(LAST_CELL)) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         copy_pend_ff  <= 1'b0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         copy_pend_ff  <= copy_pend_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      copy_addr_ff <= copy_addr_in;
      read_oob_ff  <= read_oob_in;
      if (rsp_load) begin
         rsp_col_ff  <= load_col;
         rsp_row_ff  <= load_row;
         rsp_loc_ff  <= cell_index(load_row, load_col);
         rsp_data_ff <= load_data;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.cursor_col      = rsp_col_ff;
   assign rsp.cursor_row      = rsp_row_ff;
   assign rsp.cursor_location = rsp_loc_ff;
   assign rsp.read_data       = rsp_data_ff;

   // a new response never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && !rsp.ready))
      else $error("response register overwritten");

   // cursor stays on screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_col_ff < COL_W'(COLUMNS)) && (cursor_row_ff < ROW_W'(ROWS)))
      else $error("cursor off screen");

   // sweep counter stays inside the memory while sweeping
   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL || state_ff == ST_BLANK) |-> (cnt_ff < IDX_W'(CELL_COUNT)))
      else $error("sweep address out of range");

   // pending copy only follows a scroll read
   a_copy_origin: assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> $past(state_ff == ST_SCROLL))
      else $error("copy write without scroll read");

   // no request taken while busy
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("request taken while busy");

endmodule

/* sim/text_console_char_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_engine_tb
// drives put, clear, read and no-op requests into the console engine and
// checks every response against a cycle-free model of the cursor and the
// cell memory, with random idling on both channels
// ----------------------------------------------------------------------------
module text_console_char_engine_tb;
   import tcce_pkg::*;

   // one request as driven onto the request channel
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] char_code;
      logic [NIB_W-1:0]  background;
      logic [NIB_W-1:0]  foreground;
      logic [IDX_W-1:0]  read_index;
   } console_request_type;

   // one response as it should come back
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [IDX_W-1:0]  loc;
      logic [CELL_W-1:0] data;
   } cursor_report_type;

   // two copies of the console: one runs ahead while stimulus is built,
   // the other follows the requests the engine actually takes
   localparam int LOOKAHEAD = 0;
   localparam int FOLLOWER  = 1;

   localparam int RANDOM_REQUESTS = 1000;
   localparam int INDEX_SPAN      = 1 << IDX_W;

   logic clock;
   logic reset;

   tcce_req_if req_chan ();
   tcce_rsp_if rsp_chan ();

   text_console_char_engine dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   // console copies
   logic [CELL_W-1:0] screen_shadow [2][CELL_COUNT];
   bit                shadow_known  [2][CELL_COUNT];
   int                shadow_col    [2];
   int                shadow_row    [2];

   console_request_type pending_requests [$];
   cursor_report_type   cursor_reports_due [$];

   int          req_launched;
   int          req_taken;
   int          rsp_seen;
   int          mismatches;
   int          sweep_count;
   longint      cycle_count;
   longint      cycle_limit;
   bit          stimulus_built;

   // ------------------------------------------------------------------------
   // console behavior: applies one request to copy k, returns 1 when the
   // engine has to walk the whole memory (clear or scroll)
   // ------------------------------------------------------------------------
   function automatic bit advance_console(input int k, input console_request_type rq,
                                          output cursor_report_type rep);
      int                c;
      int                r;
      int                loc;
      int                i;
      bit                swept;
      logic [CELL_W-1:0] data;
      c     = shadow_col[k];
      r     = shadow_row[k];
      swept = 1'b0;
      data  = '0;
      case (rq.command)
         CMD_PUT: begin
            if (rq.char_code == CHAR_BS) begin
               // backspace stops at the left edge
               if (c > 0) c = c - 1;
            end else if (rq.char_code == CHAR_TAB) begin
               c = c + TAB_WIDTH - (c % TAB_WIDTH);
            end else if (rq.char_code == CHAR_CR) begin
               c = 0;
            end else if (rq.char_code == CHAR_LF) begin
               c = 0;
               r = r + 1;
            end else if (rq.char_code >= PRINT_LO && rq.char_code <= PRINT_HI) begin
               screen_shadow[k][r * COLUMNS + c] =
                  {rq.background, rq.foreground, rq.char_code};
               shadow_known[k][r * COLUMNS + c] = 1'b1;
               c = c + 1;
            end
            // other control bytes and high bytes leave everything alone
            if (c >= COLUMNS) begin
               c = 0;
               r = r + 1;
            end
            if (r >= ROWS) begin
               // scroll up one row, blank the bottom row
               for (i = 0; i < BLANK_START; i++) begin
                  screen_shadow[k][i] = screen_shadow[k][i + COLUMNS];
                  shadow_known[k][i]  = shadow_known[k][i + COLUMNS];
               end
               for (i = BLANK_START; i < CELL_COUNT; i++) begin
                  screen_shadow[k][i] = BLANK_CELL;
                  shadow_known[k][i]  = 1'b1;
               end
               r     = ROWS - 1;
               swept = 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++) begin
               screen_shadow[k][i] = BLANK_CELL;
               shadow_known[k][i]  = 1'b1;
            end
            c     = 0;
            r     = 0;
            swept = 1'b1;
         end
         CMD_READ: begin
            if (rq.read_index < CELL_COUNT) data = screen_shadow[k][rq.read_index];
         end
         default: ;
      endcase
      shadow_col[k] = c;
      shadow_row[k] = r;
      loc           = r * COLUMNS + c;
      rep.col       = c[COL_W-1:0];
      rep.row       = r[ROW_W-1:0];
      rep.loc       = loc[IDX_W-1:0];
      rep.data      = data;
      return swept;
   endfunction

   // queue a request and run it through the lookahead copy
   task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                input logic [NIB_W-1:0] bg, input logic [NIB_W-1:0] fg,
                                input logic [IDX_W-1:0] idx);
      console_request_type rq;
      cursor_report_type   unused;
      rq = '{command: cmd, char_code: ch, background: bg, foreground: fg, read_index: idx};
      pending_requests.push_back(rq);
      if (advance_console(LOOKAHEAD, rq, unused)) sweep_count++;
   endtask

   // one line per mismatch
   task automatic report_mismatch(input string field, input longint got,
                                  input longint want);
      mismatches++;
      $display("mismatch on response %0d: %s got 0x%0h expected 0x%0h",
               rsp_seen, field, got, want);
   endtask

   // ------------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
   end

   // every channel input known from time zero
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.command    = '0;
      req_chan.char_code  = '0;
      req_chan.background = '0;
      req_chan.foreground = '0;
      req_chan.read_index = '0;
      rsp_chan.ready      = 1'b0;
   end

   // ------------------------------------------------------------------------
   // request driver: changes at the falling edge, holds until taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_launched == req_taken) begin
         // no request outstanding, maybe launch the next one
         if (pending_requests.size() != 0 &&
             ((req_launched >= 400 && req_launched < 650) || $urandom_range(99) >= 14)) begin
            console_request_type rq;
            rq = pending_requests.pop_front();
            req_chan.command    <= rq.command;
            req_chan.char_code  <= rq.char_code;
            req_chan.background <= rq.background;
            req_chan.foreground <= rq.foreground;
            req_chan.read_index <= rq.read_index;
            req_chan.valid      <= 1'b1;
            req_launched++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response back-pressure, quiet window in the middle of the run
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= (rsp_seen >= 400 && rsp_seen < 650) || ($urandom_range(99) >= 14);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: both channels sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         // request taken: predict its response from the follower copy
         if (req_chan.valid && req_chan.ready) begin
            console_request_type rq;
            cursor_report_type   rep;
            rq.command    = req_chan.command;
            rq.char_code  = req_chan.char_code;
            rq.background = req_chan.background;
            rq.foreground = req_chan.foreground;
            rq.read_index = req_chan.read_index;
            void'(advance_console(FOLLOWER, rq, rep));
            cursor_reports_due.push_back(rep);
            req_taken++;
         end
         // response taken: compare with the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (cursor_reports_due.size() == 0) begin
               report_mismatch("response with no request outstanding", 0, 0);
            end else begin
               cursor_report_type want;
               want = cursor_reports_due.pop_front();
               if (rsp_chan.cursor_col !== want.col)
                  report_mismatch("cursor_col", longint'(rsp_chan.cursor_col),
                                  longint'(want.col));
               if (rsp_chan.cursor_row !== want.row)
                  report_mismatch("cursor_row", longint'(rsp_chan.cursor_row),
                                  longint'(want.row));
               if (rsp_chan.cursor_location !== want.loc)
                  report_mismatch("cursor_location", longint'(rsp_chan.cursor_location),
                                  longint'(want.loc));
               if (rsp_chan.read_data !== want.data)
                  report_mismatch("read_data", longint'(rsp_chan.read_data),
                                  longint'(want.data));
            end
            rsp_seen++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int                n;
      int                roll;
      int                croll;
      int                probe;
      int                j;
      bit                found;
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;

      req_launched   = 0;
      req_taken      = 0;
      rsp_seen       = 0;
      mismatches     = 0;
      sweep_count    = 0;
      cycle_count    = 0;
      cycle_limit    = 0;
      stimulus_built = 1'b0;
      for (int k = 0; k < 2; k++) begin
         shadow_col[k] = 0;
         shadow_row[k] = 0;
         for (int i = 0; i < CELL_COUNT; i++) begin
            screen_shadow[k][i] = '0;
            shadow_known[k][i]  = 1'b0;
         end
      end

      // directed part
      // a character before any clear, read back from the cell it wrote
      queue_request(CMD_PUT, 8'h41, 4'hF, 4'h0, 11'h000);
      queue_request(CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0);
      // backspace, then backspace again at the left edge
      queue_request(CMD_PUT, CHAR_BS, 4'h0, 4'h0, 11'h7FF);
      queue_request(CMD_PUT, CHAR_BS, 4'h0, 4'h0, 11'h000);
      queue_request(CMD_CLEAR, 8'hFF, 4'hF, 4'hF, 11'h7FF);
      // last cell, and indexes past the end of the memory
      queue_request(CMD_READ, 8'h00, 4'h0, 4'h0, 11'(LAST_CELL));
      queue_request(CMD_READ, 8'h00, 4'h0, 4'h0, 11'h7FF);
      queue_request(CMD_READ, 8'h00, 4'h0, 4'h0, 11'(CELL_COUNT));
      // printable range edges and attribute extremes
      queue_request(CMD_PUT, PRINT_LO, 4'h0, 4'hF, 11'h000);
      queue_request(CMD_PUT, PRINT_HI, 4'hF, 4'hF, 11'h000);
      // high bytes and stray control bytes are ignored, then tab, CR, LF, no-op, read
      queue_request(CMD_PUT, 8'h80, 4'hA, 4'h5, 11'h000);
      queue_request(CMD_PUT, 8'hFF, 4'h5, 4'hA, 11'h000);
      queue_request(CMD_PUT, 8'h00, 4'h0, 4'h0, 11'h000);
      queue_request(CMD_PUT, 8'h1F, 4'h0, 4'h0, 11'h000);
      queue_request(CMD_PUT, CHAR_TAB, 4'h0, 4'h0, 11'h000);
      queue_request(CMD_PUT, CHAR_CR, 4'h0, 4'h0, 11'h000);
      queue_request(CMD_PUT, CHAR_LF, 4'h0, 4'h0, 11'h000);
      queue_request(CMD_NOP, 8'hFF, 4'hF, 4'hF, 11'h7FF);
      queue_request(CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1);
      // tabs across a whole row until the column wraps
      for (n = 0; n < COLUMNS / TAB_WIDTH; n++)
         queue_request(CMD_PUT, CHAR_TAB, 4'h0, 4'h0, 11'h000);

      // random part: mostly text with control bytes, some reads
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         roll = $urandom_range(99);
         ch   = CHAR_W'($urandom_range(255));
         idx  = IDX_W'($urandom_range(INDEX_SPAN - 1));
         if (roll < 1) begin
            cmd = CMD_CLEAR;
         end else if (roll < 4) begin
            cmd = CMD_NOP;
         end else if (roll < 22) begin
            cmd = CMD_READ;
            if ($urandom_range(99) < 12) begin
               idx = IDX_W'($urandom_range(INDEX_SPAN - 1, CELL_COUNT));
            end else begin
               // only cells that hold a known value get read
               probe = $urandom_range(CELL_COUNT - 1);
               found = 1'b0;
               for (j = 0; j < CELL_COUNT && !found; j++) begin
                  if (shadow_known[LOOKAHEAD][(probe + j) % CELL_COUNT]) begin
                     idx   = IDX_W'((probe + j) % CELL_COUNT);
                     found = 1'b1;
                  end
               end
               if (!found) idx = IDX_W'(CELL_COUNT);
            end
         end else begin
            cmd   = CMD_PUT;
            croll = $urandom_range(99);
            if (croll < 62)      ch = CHAR_W'($urandom_range(PRINT_HI, PRINT_LO));
            else if (croll < 70) ch = CHAR_LF;
            else if (croll < 73) ch = CHAR_CR;
            else if (croll < 78) ch = CHAR_BS;
            else if (croll < 83) ch = CHAR_TAB;
            else if (croll < 90) ch = CHAR_W'($urandom_range(PRINT_LO - 1, 0));
            else                 ch = CHAR_W'($urandom_range(255, 128));
         end
         queue_request(cmd, ch, NIB_W'($urandom_range(15)), NIB_W'($urandom_range(15)),
                       idx);
      end

      // generous bound from the requests and the sweeps the stimulus causes
      cycle_limit    = 4 * (longint'(pending_requests.size()) * 40 +
                            longint'(sweep_count) * (CELL_COUNT + 100)) + 20000;
      stimulus_built = 1'b1;

      // drain: everything sent, taken and answered
      while (pending_requests.size() != 0 || req_launched != req_taken ||
             cursor_reports_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("text_console_char_engine verification clean");
      end else begin
         $display("text_console_char_engine verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      wait (stimulus_built);
      while (cycle_count < cycle_limit) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("text_console_char_engine verification failed");
      $finish;
   end

endmodule

/* text_console_char_engine.f */
rtl/core/tcce_pkg.sv
rtl/core/tcce_if.sv
rtl/core/tcce_screen_ram.sv
rtl/core/tcce_cursor_step.sv
rtl/core/text_console_char_engine.sv
sim/text_console_char_engine_tb.sv
